// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types and constants of the I2C master byte engine.
// Used by i2cm_front, i2cm_back and i2c_master_byte_engine; depends on nothing.
package i2cm_pkg;

    // Operation codes on the command channel.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Configuration register indexes and reset values.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_LIMIT   = 1'b1;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd125;
    localparam logic [16:0] ACK_LIMIT_RESET   = 17'h10000;

    // Item class as decided by the front end.
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_TICK  = 3'd1,
        KIND_START = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_WRITE = 3'd4,
        KIND_READ  = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data_byte;
        logic        send_ack;
        logic        sda_in;
    } item_t;

    // Bus sequencer phases.
    typedef enum logic [14:0] {
        PH_IDLE  = 15'b000000000000001,
        PH_ST1   = 15'b000000000000010,
        PH_ST2   = 15'b000000000000100,
        PH_ST3   = 15'b000000000001000,
        PH_ST4   = 15'b000000000010000,
        PH_SP1   = 15'b000000000100000,
        PH_SP2   = 15'b000000001000000,
        PH_SP3   = 15'b000000010000000,
        PH_SP4   = 15'b000000100000000,
        PH_BLOW  = 15'b000001000000000,
        PH_BDATA = 15'b000010000000000,
        PH_BHIGH = 15'b000100000000000,
        PH_BEND  = 15'b001000000000000,
        PH_AWAIT = 15'b010000000000000,
        PH_AEND  = 15'b100000000000000
    } phase_t;

endpackage

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// I2C master byte engine, top level.
// Command channel (cmd_valid/cmd_ready): one transfer per tick or byte-level
// command; operation 0 is a tick carrying the sampled SDA level, 1 start,
// 2 stop, 3 write byte, 4 read byte, other codes are ignored.
// Result channel (res_valid/res_ready): exactly one result per command
// transfer, in order, carrying the SCL/SDA drive levels, busy, done, ACK,
// timeout and the last read byte as they stand after that item.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 half
// period in ticks, 1 ACK timeout limit) in the same cycle; write only idle.
// Throughput is one item per clock cycle while each result is taken: the
// sequencer retires one queued item per cycle, and its state register
// doubles as the result register. A command transfer is first written into
// the queue; the sequencer pops it once the previous result has been taken
// and registers its result, raising res_valid.
// When the receiver stalls, the result holds and the queue of QUEUE_DEPTH
// entries keeps taking items; cmd_ready drops only when the queue is full.
// Reset: queue empty, sequencer idle, SCL and SDA released, half period 125
// ticks, ACK timeout limit 65536 ticks.
module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  logic [2:0]             operation,
    input  logic [7:0]             data_byte,
    input  logic                   send_ack,
    input  logic                   sda_in,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic                   scl_out,
    output logic                   sda_out,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   ack_received,
    output logic                   timed_out,
    output logic [7:0]             read_data
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .operation (operation),
        .data_byte (data_byte),
        .send_ack  (send_ack),
        .sda_in    (sda_in),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    i2cm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .ack_received (ack_received),
        .timed_out    (timed_out),
        .read_data    (read_data)
    );

endmodule

// ===== hw/rtl/i2cm_front.sv =====
// Front end of the I2C master byte engine: accepts command-channel transfers,
// classifies the operation and queues the items. Depends on i2cm_pkg.
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [2:0] operation,
    input  logic [7:0] data_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    item_t              new_item;
    logic               push;

    always_comb
    begin
        new_item.data_byte = data_byte;
        new_item.send_ack  = send_ack;
        new_item.sda_in    = sda_in;
        unique case (operation)
            OP_TICK:  new_item.kind = KIND_TICK;
            OP_START: new_item.kind = KIND_START;
            OP_STOP:  new_item.kind = KIND_STOP;
            OP_WRITE: new_item.kind = KIND_WRITE;
            OP_READ:  new_item.kind = KIND_READ;
            default:  new_item.kind = KIND_NONE;
        endcase
    end

    assign cmd_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = cmd_valid && cmd_ready;
    assign q_valid   = (count_reg != '0);
    assign q_item    = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// ===== hw/rtl/i2cm_back.sv =====
// Back end of the I2C master byte engine: the bus sequencer with its divider,
// ACK timeout and configuration registers; its state is the result register.
// Depends on i2cm_pkg.
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  item_t                  q_item,
    output logic                   q_pop,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic                   scl_out,
    output logic                   sda_out,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   ack_received,
    output logic                   timed_out,
    output logic [7:0]             read_data
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_data_reg, shift_data_next;
    logic [15:0] div_reg, div_next;
    logic [16:0] wait_reg, wait_next;
    logic        ack_choice_reg, ack_choice_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        is_read_reg, is_read_next;
    logic        ack_flag_reg, ack_flag_next;
    logic        timeout_flag_reg, timeout_flag_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        done_reg, done_next;
    logic        res_valid_reg, res_valid_next;
    logic [15:0] half_period_reg, half_period_next;
    logic [16:0] ack_limit_reg, ack_limit_next;

    logic [15:0] hp;
    logic [16:0] lim;
    logic [15:0] div_inc;
    logic [16:0] wait_inc;
    logic        idle;

    assign idle     = (phase_reg == PH_IDLE);
    assign q_pop    = q_valid && (!res_valid_reg || res_ready);
    assign hp       = (half_period_reg == '0) ? 16'd1 : half_period_reg;
    assign lim      = (ack_limit_reg == '0) ? 17'd1 : ack_limit_reg;
    assign div_inc  = 16'(div_reg + 16'd1);
    assign wait_inc = 17'(wait_reg + 17'd1);

    always_comb
    begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        shift_data_next   = shift_data_reg;
        div_next          = div_reg;
        wait_next         = wait_reg;
        ack_choice_next   = ack_choice_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        is_read_next      = is_read_reg;
        ack_flag_next     = ack_flag_reg;
        timeout_flag_next = timeout_flag_reg;
        read_data_next    = read_data_reg;
        done_next         = done_reg;
        half_period_next  = half_period_reg;
        ack_limit_next    = ack_limit_reg;
        res_valid_next    = res_valid_reg && !res_ready;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_PERIOD: half_period_next = cfg_data[15:0];
                REG_ACK_LIMIT:   ack_limit_next   = cfg_data;
                default: ;
            endcase
        end

        if (q_pop)
        begin
            res_valid_next = 1'b1;
            done_next      = 1'b0;
            unique case (q_item.kind)
                KIND_TICK:
                begin
                    if (!idle)
                    begin
                        if (phase_reg == PH_AWAIT)
                        begin
                            // SDA is checked on every tick while waiting for the ACK.
                            if (!q_item.sda_in)
                            begin
                                ack_flag_next = 1'b1;
                                div_next      = '0;
                                phase_next    = PH_AEND;
                            end
                            else
                            begin
                                wait_next = wait_inc;
                                if (wait_inc >= lim)
                                begin
                                    timeout_flag_next = 1'b1;
                                    ack_flag_next     = 1'b0;
                                    div_next          = '0;
                                    phase_next        = PH_SP1;
                                end
                            end
                        end
                        else if (div_inc < hp)
                        begin
                            div_next = div_inc;
                        end
                        else
                        begin
                            div_next = '0;
                            unique case (phase_reg)
                                PH_ST1:
                                begin
                                    sda_next   = 1'b1;
                                    phase_next = PH_ST2;
                                end
                                PH_ST2:
                                begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_ST3;
                                end
                                PH_ST3:
                                begin
                                    sda_next   = 1'b0;
                                    phase_next = PH_ST4;
                                end
                                PH_ST4:
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                                PH_SP1:
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PH_SP2;
                                end
                                PH_SP2:
                                begin
                                    sda_next   = 1'b0;
                                    phase_next = PH_SP3;
                                end
                                PH_SP3:
                                begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_SP4;
                                end
                                PH_SP4:
                                begin
                                    sda_next   = 1'b1;
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                                PH_BLOW:
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PH_BDATA;
                                end
                                PH_BDATA:
                                begin
                                    // The ninth bit is the ACK slot: driven on reads,
                                    // released on writes.
                                    if (bit_index_reg[3])
                                    begin
                                        sda_next = is_read_reg ? !ack_choice_reg : 1'b1;
                                    end
                                    else
                                    begin
                                        sda_next = is_read_reg ? 1'b1 : shift_data_reg[7];
                                    end
                                    phase_next = PH_BHIGH;
                                end
                                PH_BHIGH:
                                begin
                                    scl_next = 1'b1;
                                    if (!is_read_reg && bit_index_reg[3])
                                    begin
                                        wait_next  = '0;
                                        phase_next = PH_AWAIT;
                                    end
                                    else
                                    begin
                                        phase_next = PH_BEND;
                                    end
                                end
                                PH_BEND:
                                begin
                                    if (bit_index_reg[3])
                                    begin
                                        read_data_next = shift_data_reg;
                                        phase_next     = PH_IDLE;
                                        done_next      = 1'b1;
                                    end
                                    else
                                    begin
                                        shift_data_next = {shift_data_reg[6:0],
                                                           is_read_reg && q_item.sda_in};
                                        bit_index_next  = bit_index_reg + 4'd1;
                                        phase_next      = PH_BLOW;
                                    end
                                end
                                PH_AEND:
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                                default: phase_next = PH_IDLE;
                            endcase
                        end
                    end
                end
                KIND_START, KIND_STOP, KIND_WRITE, KIND_READ:
                begin
                    if (idle)
                    begin
                        ack_flag_next     = 1'b0;
                        timeout_flag_next = 1'b0;
                        div_next          = '0;
                        bit_index_next    = '0;
                        unique case (q_item.kind)
                            KIND_START: phase_next = PH_ST1;
                            KIND_STOP:  phase_next = PH_SP1;
                            KIND_WRITE:
                            begin
                                is_read_next    = 1'b0;
                                shift_data_next = q_item.data_byte;
                                phase_next      = PH_BLOW;
                            end
                            default:
                            begin
                                is_read_next    = 1'b1;
                                shift_data_next = '0;
                                ack_choice_next = q_item.send_ack;
                                phase_next      = PH_BLOW;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= '0;
            shift_data_reg   <= '0;
            div_reg          <= '0;
            wait_reg         <= '0;
            ack_choice_reg   <= 1'b0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
            is_read_reg      <= 1'b0;
            ack_flag_reg     <= 1'b0;
            timeout_flag_reg <= 1'b0;
            read_data_reg    <= '0;
            done_reg         <= 1'b0;
            res_valid_reg    <= 1'b0;
            half_period_reg  <= HALF_PERIOD_RESET;
            ack_limit_reg    <= ACK_LIMIT_RESET;
        end
        else
        begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            shift_data_reg   <= shift_data_next;
            div_reg          <= div_next;
            wait_reg         <= wait_next;
            ack_choice_reg   <= ack_choice_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
            is_read_reg      <= is_read_next;
            ack_flag_reg     <= ack_flag_next;
            timeout_flag_reg <= timeout_flag_next;
            read_data_reg    <= read_data_next;
            done_reg         <= done_next;
            res_valid_reg    <= res_valid_next;
            half_period_reg  <= half_period_next;
            ack_limit_reg    <= ack_limit_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign scl_out      = scl_reg;
    assign sda_out      = sda_reg;
    assign busy_res     = !idle;
    assign done_res     = done_reg;
    assign ack_received = ack_flag_reg;
    assign timed_out    = timeout_flag_reg;
    assign read_data    = read_data_reg;

`ifndef SYNTHESIS
    a_done_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && done_reg) |-> idle)
        else $error("done reported while a command is still running");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        timeout_flag_reg |-> !ack_flag_reg)
        else $error("ACK and timeout reported together");

    a_ack_wait_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_AWAIT) |-> (scl_reg && sda_reg))
        else $error("ACK wait without SCL high and SDA released");

    a_bit_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= 4'd8)
        else $error("bit index beyond the ACK slot");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(phase_reg)))
        else $error("sequencer advanced while the result was stalled");
`endif

endmodule
